// ===== hw/rtl/stkc_pkg.sv =====
// Shared types and constants of the stable top-k selection block.
package stkc_pkg;

  localparam int ID_W   = 16;
  localparam int CNT_W  = 16;
  localparam int RANK_W = 4;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] count;
  } entry_t;

  // Operation applied to every cell of the chain together.
  typedef struct packed {
    logic insert;
    logic shift;
  } ctrl_t;

endpackage

// ===== hw/rtl/stkc_cell.sv =====
// One rank cell of the sorted chain: holds one entry and trades it with its neighbors.
module stkc_cell
  import stkc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  ctrl_t  ctrl,
  input  entry_t new_entry,
  input  entry_t left_entry,
  input  logic   left_valid,
  input  logic   left_keep,
  input  entry_t right_entry,
  input  logic   right_valid,
  output entry_t entry,
  output logic   valid,
  output logic   keep
);

  // Equal counts stay ahead of the newcomer, which keeps arrival order.
  assign keep = valid && (entry.count >= new_entry.count);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.insert) begin
      if (!keep) begin
        if (left_keep) begin
          entry <= new_entry;
        end else begin
          entry <= left_entry;
        end
      end
      valid <= valid | left_valid;
    end else if (ctrl.shift) begin
      entry <= right_entry;
      valid <= right_valid;
    end
  end

endmodule

// ===== hw/rtl/stable_top_k_by_count.sv =====
// Top level of the stable top-k selection block: a chain of rank cells and the readout control.
//
// The block keeps the TOP_COUNT records with the most wins, sorted in descending order of
// win count; records with equal counts keep their arrival order. A record is taken by a
// transfer at a clock edge where start is high and busy is low, and is placed into the chain
// of rank cells in that same edge, so a new record can follow in every cycle while busy is
// low. When the stored set is full, a record whose count does not beat the lowest kept entry
// is dropped. The record flagged by final_record is inserted like any other, after which the
// block raises busy and reads the kept entries out, one per cycle from rank 1 onward: each
// result is shown for exactly one cycle with result_valid high, and the receiver cannot stall
// it. The readout shifts the chain toward cell 0, giving one result per kept entry (1 to
// TOP_COUNT), and it leaves the chain empty for the next set; busy falls in the cycle after
// the result carrying last_rank. The rank output is four bits wide and wraps when TOP_COUNT
// exceeds 15.
module stable_top_k_by_count
  import stkc_pkg::*;
#(
  parameter int TOP_COUNT = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [ID_W-1:0]   player_id,
  input  logic [CNT_W-1:0]  win_count,
  input  logic              final_record,
  output logic              result_valid,
  output logic [RANK_W-1:0] rank,
  output logic [ID_W-1:0]   ranked_id,
  output logic [CNT_W-1:0]  ranked_count,
  output logic              last_rank
);

  logic              accept;
  logic              draining;
  logic [RANK_W-1:0] rank_cnt;
  ctrl_t             ctrl;
  entry_t            new_entry;

  // One extra slot past the last cell stands for an empty neighbor.
  entry_t ent   [0:TOP_COUNT];
  logic   vld   [0:TOP_COUNT];
  logic   kp    [0:TOP_COUNT-1];

  assign accept          = start && !busy;
  assign busy            = draining;
  assign ctrl.insert     = accept;
  assign ctrl.shift      = draining;
  assign new_entry.id    = player_id;
  assign new_entry.count = win_count;
  assign ent[TOP_COUNT]  = '0;
  assign vld[TOP_COUNT]  = 1'b0;

  genvar g;
  generate
    for (g = 0; g < TOP_COUNT; g++) begin : g_cell
      entry_t l_ent;
      logic   l_vld;
      logic   l_kp;
      if (g == 0) begin : g_head
        // The head cell has nothing above it: it takes the new record unless it keeps.
        assign l_ent = new_entry;
        assign l_vld = 1'b1;
        assign l_kp  = 1'b1;
      end else begin : g_body
        assign l_ent = ent[g-1];
        assign l_vld = vld[g-1];
        assign l_kp  = kp[g-1];
      end
      stkc_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .new_entry   (new_entry),
        .left_entry  (l_ent),
        .left_valid  (l_vld),
        .left_keep   (l_kp),
        .right_entry (ent[g+1]),
        .right_valid (vld[g+1]),
        .entry       (ent[g]),
        .valid       (vld[g]),
        .keep        (kp[g])
      );
    end
  endgenerate

  // Readout presents cell 0 each cycle; the run ends when cell 1 holds nothing.
  assign result_valid = draining;
  assign rank         = rank_cnt;
  assign ranked_id    = ent[0].id;
  assign ranked_count = ent[0].count;
  assign last_rank    = draining && !vld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      rank_cnt <= '0;
    end else if (accept) begin
      draining <= final_record;
      rank_cnt <= RANK_W'(1);
    end else if (draining) begin
      if (!vld[1]) begin
        draining <= 1'b0;
      end
      rank_cnt <= rank_cnt + RANK_W'(1);
    end
  end

endmodule

// ===== sim/stable_top_k_by_count_tb.sv =====
// Self-checking testbench for the stable top-k selection block, with its scoreboard.
module stable_top_k_by_count_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import stkc_pkg::*;

  // The block is built with the default depth of ten kept entries.
  localparam int KEEP      = 10;
  localparam int HALF_CLK  = 10;
  // Cycles a readout may still need after the last expected result.
  localparam int SETTLE    = KEEP + 4;
  localparam int RAND_ITEMS = 370;
  // Watchdog time in ns: far above the slowest correct run, with every record behind a gap
  // and every set read out at full depth.
  localparam int WATCHDOG_NS = 200_000 * 2 * HALF_CLK;

  // One ranked entry as the block reports it during the readout.
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [ID_W-1:0]   id;
    logic [CNT_W-1:0]  count;
    logic              last;
  } ranked_t;

  // Scoreboard: it mirrors the kept set, turns each final record into the expected
  // readout, and compares every result that the block emits against it in order.
  class top_k_scoreboard;
    entry_t      kept [KEEP];
    int unsigned filled;
    ranked_t     expected_ranks [$];
    int          mismatch_count;

    function new();
      filled = 0;
      mismatch_count = 0;
    endfunction

    // Stable descending insertion: the record goes after every entry whose count is
    // greater than or equal to its own; the lowest entry falls out of a full set.
    function void insert_ranked(logic [ID_W-1:0] id, logic [CNT_W-1:0] cnt);
      int unsigned pos;
      int unsigned i;
      pos = 0;
      while (pos < filled && kept[pos].count >= cnt) pos++;
      if (pos >= KEEP) return;
      i = (filled < KEEP) ? filled : KEEP - 1;
      while (i > pos) begin
        kept[i] = kept[i-1];
        i--;
      end
      kept[pos].id = id;
      kept[pos].count = cnt;
      if (filled < KEEP) filled++;
    endfunction

    function void note_record(logic [ID_W-1:0] id, logic [CNT_W-1:0] cnt, logic fin);
      ranked_t r;
      insert_ranked(id, cnt);
      if (!fin) return;
      for (int unsigned k = 0; k < filled; k++) begin
        r.rank  = RANK_W'(k + 1);
        r.id    = kept[k].id;
        r.count = kept[k].count;
        r.last  = (k + 1 == filled);
        expected_ranks.push_back(r);
      end
      filled = 0;
    endfunction

    function void check_result(ranked_t got);
      ranked_t want;
      if (expected_ranks.size() == 0) begin
        $error("unexpected result: rank %0d id 0x%04h count %0d", got.rank, got.id, got.count);
        mismatch_count++;
        return;
      end
      want = expected_ranks.pop_front();
      if (got.rank !== want.rank) begin
        $error("rank: expected %0d, actual %0d", want.rank, got.rank);
        mismatch_count++;
      end
      if (got.id !== want.id) begin
        $error("ranked_id: expected 0x%04h, actual 0x%04h", want.id, got.id);
        mismatch_count++;
      end
      if (got.count !== want.count) begin
        $error("ranked_count: expected %0d, actual %0d", want.count, got.count);
        mismatch_count++;
      end
      if (got.last !== want.last) begin
        $error("last_rank: expected %0b, actual %0b", want.last, got.last);
        mismatch_count++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [ID_W-1:0]   player_id;
  logic [CNT_W-1:0]  win_count;
  logic              final_record;
  logic              result_valid;
  logic [RANK_W-1:0] rank;
  logic [ID_W-1:0]   ranked_id;
  logic [CNT_W-1:0]  ranked_count;
  logic              last_rank;

  top_k_scoreboard board = new();
  int              items_sent;

  stable_top_k_by_count #(
    .TOP_COUNT(KEEP)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .player_id   (player_id),
    .win_count   (win_count),
    .final_record(final_record),
    .result_valid(result_valid),
    .rank        (rank),
    .ranked_id   (ranked_id),
    .ranked_count(ranked_count),
    .last_rank   (last_rank)
  );

  initial clk = 1'b0;
  always #(HALF_CLK) clk = ~clk;

  // Results cannot be held off, so every strobed cycle is a transfer. The outputs are
  // read at the rising edge, before the block's own updates of that edge land.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      board.check_result('{rank: rank, id: ranked_id, count: ranked_count, last: last_rank});
    end
  end

  // Presents one record from the falling edge on and holds it until a rising edge sees
  // busy low, which is the transfer. Start is left high so that a following record can
  // go out back to back; only the idle task lowers it.
  task automatic send_record(logic [ID_W-1:0] id, logic [CNT_W-1:0] cnt, logic fin);
    @(negedge clk);
    start        <= 1'b1;
    player_id    <= id;
    win_count    <= cnt;
    final_record <= fin;
    do @(posedge clk); while (busy);
    board.note_record(id, cnt, fin);
    items_sent++;
  endtask

  // Keeps start low for the given number of cycles, with junk on the record fields.
  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start        <= 1'b0;
      player_id    <= ID_W'($urandom);
      win_count    <= CNT_W'($urandom);
      final_record <= 1'($urandom);
    end
  endtask

  // Waits until every expected result has arrived, then lets the block settle.
  task automatic drain();
    int guard;
    guard = 0;
    while (board.expected_ranks.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // Sort keys: half from a narrow range so that ties are common, the rest full-range values
  // and both extremes.
  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return CNT_W'($urandom_range(0, 7));
      5, 6, 7:       return CNT_W'($urandom);
      8:             return '0;
      default:       return '1;
    endcase
  endfunction

  initial begin
    int set_len;
    int sets_done;
    logic quiet;

    rst          = 1'b1;
    start        = 1'b0;
    player_id    = '0;
    win_count    = '0;
    final_record = 1'b0;
    items_sent   = 0;
    sets_done    = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Sets of a single final record at both extremes of every field, then a set of two.
    send_record(16'hFFFF, 16'hFFFF, 1'b1);
    send_record(16'h0000, 16'h0000, 1'b1);
    send_record(16'hAAAA, 16'h5555, 1'b0);
    send_record(16'h5555, 16'hAAAA, 1'b1);

    // Equal counts keep their arrival order; a zero count ends up last.
    send_record(16'd1, 16'd5, 1'b0);
    send_record(16'd2, 16'd5, 1'b0);
    send_record(16'd3, 16'd7, 1'b0);
    send_record(16'd4, 16'd5, 1'b0);
    send_record(16'd5, 16'd0, 1'b1);

    // Fill the set with ties, then offer a record that only equals the lowest entry
    // (dropped), one that beats it (inserted at the top, lowest falls out), and a final
    // record too weak to stay in a full set.
    for (int i = 0; i < KEEP; i++) send_record(ID_W'(16'h10 + i), 16'd100, 1'b0);
    send_record(16'h20, 16'd100, 1'b0);
    send_record(16'h21, 16'd101, 1'b0);
    send_record(16'h22, 16'd0, 1'b1);
    idle_cycles(1);
    drain();

    // Random sets. The middle stretch runs with no gaps at all; elsewhere about one
    // record in fourteen is preceded by a short idle period.
    while (items_sent < RAND_ITEMS) begin
      set_len = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 25) : $urandom_range(1, 12);
      for (int i = 0; i < set_len; i++) begin
        quiet = (items_sent >= 150 && items_sent < 240);
        if (!quiet && $urandom_range(0, 99) < 7) idle_cycles($urandom_range(1, 4));
        send_record(ID_W'($urandom), pick_count(), i == set_len - 1);
      end
      sets_done++;
      // Once in the run the sender stops until the whole readout has been checked.
      if (sets_done == 12) begin
        idle_cycles(1);
        drain();
      end
    end

    idle_cycles(1);
    drain();
    if (board.expected_ranks.size() != 0) begin
      $error("%0d expected results never arrived", board.expected_ranks.size());
      board.mismatch_count++;
    end

    if (board.mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin
    #(WATCHDOG_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/stkc_pkg.sv
hw/rtl/stkc_cell.sv
hw/rtl/stable_top_k_by_count.sv
sim/stable_top_k_by_count_tb.sv
